[design/lncc_pkg.sv]
// ----------------------------------------------------------------------------
// lncc_pkg
// Shared types, constants and width helpers of the lagged normalized
// cross-correlation block.
// ----------------------------------------------------------------------------
package lncc_pkg;

  localparam int WINDOW_DEPTH_DEF  = 256;
  localparam int MAX_LAG_LIMIT_DEF = 31;

  localparam int SAMPLE_W   = 16;
  localparam int LAG_W      = 6;
  localparam int MAX_LAG_W  = 5;
  localparam int CORR_W     = 16;
  localparam int CORR_MAG_W = 15;
  localparam int QUOT_W     = 30;
  localparam int FRAC_SHIFT = 16;
  localparam int OUT_DW     = 24;

  localparam logic [CORR_MAG_W-1:0] CORR_ONE    = 15'd16384;
  localparam logic [MAX_LAG_W-1:0]  MAX_LAG_RST = 5'd8;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [0:0] REG_MAX_LAG = 1'b0;

  typedef struct packed {
    logic                       missing;
    logic signed [SAMPLE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic                  done;
    logic [CORR_MAG_W-1:0] mag;
  } qd_result_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_STATS,
    ST_SD_F,
    ST_SD_H,
    ST_DEN,
    ST_SWEEP,
    ST_DIV,
    ST_OUT
  } ctl_state_t;

  typedef enum logic [2:0] {
    SD_IDLE,
    SD_SQ,
    SD_DIV,
    SD_SUB,
    SD_ROOT,
    SD_DONE
  } sd_state_t;

  typedef enum logic [1:0] {
    QD_IDLE,
    QD_RUN,
    QD_DONE
  } qd_state_t;

  function automatic int cnt_width(int depth);
    return $clog2(depth + 1);
  endfunction

  function automatic int s1_width(int depth);
    return SAMPLE_W + cnt_width(depth);
  endfunction

  function automatic int s2_width(int depth);
    return 2 * SAMPLE_W - 1 + cnt_width(depth);
  endfunction

  function automatic int sd_width(int depth);
    return (s2_width(depth) + FRAC_SHIFT + 1) / 2;
  endfunction

endpackage

[design/lncc_store.sv]
// ----------------------------------------------------------------------------
// lncc_store
// Sample memories for both series, one write port at the fill position and
// one registered read port per series.
// ----------------------------------------------------------------------------
module lncc_store #(
  parameter int WINDOW_DEPTH = lncc_pkg::WINDOW_DEPTH_DEF,
  localparam int AW = $clog2(WINDOW_DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  lncc_pkg::entry_t wr_f,
  input  lncc_pkg::entry_t wr_h,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr_f,
  input  logic [AW-1:0]    rd_addr_h,
  output lncc_pkg::entry_t rd_f,
  output lncc_pkg::entry_t rd_h
);
  import lncc_pkg::*;

  entry_t f_mem [WINDOW_DEPTH];
  entry_t h_mem [WINDOW_DEPTH];
  entry_t rd_f_r;
  entry_t rd_h_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      f_mem[wr_addr] <= wr_f;
      h_mem[wr_addr] <= wr_h;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_f_r <= f_mem[rd_addr_f];
      rd_h_r <= h_mem[rd_addr_h];
    end
  end

  assign rd_f = rd_f_r;
  assign rd_h = rd_h_r;

endmodule

[design/lncc_sd.sv]
// ----------------------------------------------------------------------------
// lncc_sd
// Standard deviation unit: S = s2 - ceil(s1^2 / k), then sd = isqrt(S << 16)
// in Q.8. One square, a bit-serial divide and a bit-serial root.
// ----------------------------------------------------------------------------
module lncc_sd #(
  parameter int WINDOW_DEPTH = lncc_pkg::WINDOW_DEPTH_DEF,
  localparam int CW  = lncc_pkg::cnt_width(WINDOW_DEPTH),
  localparam int S1W = lncc_pkg::s1_width(WINDOW_DEPTH),
  localparam int S2W = lncc_pkg::s2_width(WINDOW_DEPTH),
  localparam int SDW = lncc_pkg::sd_width(WINDOW_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [CW-1:0]         k,
  input  logic signed [S1W-1:0] s1,
  input  logic [S2W-1:0]        s2,
  output logic                  done,
  output logic [SDW-1:0]        sd
);
  import lncc_pkg::*;

  localparam int AMAGW = S1W - 1;
  localparam int SQW   = 2 * AMAGW;
  localparam int VW    = 2 * SDW;
  localparam int DW    = ((S2W > SQW) ? S2W : SQW) + 1;
  localparam int CNTW  = $clog2(SQW + 1);

  sd_state_t         state_r, state_nxt;
  logic [CW-1:0]     k_r;
  logic [AMAGW-1:0]  a_r;
  logic [S2W-1:0]    s2_r;
  logic [SQW-1:0]    sq_r;
  logic [SQW-1:0]    quo_r;
  logic [CW-1:0]     rem_r;
  logic [CNTW-1:0]   cnt_r;
  logic [VW-1:0]     v_r;
  logic [VW-1:0]     root_r;
  logic [VW-1:0]     bit_r;

  logic [S1W-1:0]    s1_abs;
  logic [CW:0]       rem_sh;
  logic              rem_ge;
  logic [DW-1:0]     s_full;
  logic [VW-1:0]     trial;
  logic              k_small;

  assign s1_abs  = s1[S1W-1] ? S1W'(-s1) : S1W'(s1);
  assign rem_sh  = {rem_r, sq_r[SQW-1]};
  assign rem_ge  = rem_sh >= {1'b0, k_r};
  assign s_full  = DW'(s2_r) - DW'(quo_r) - DW'(rem_r != '0);
  assign trial   = root_r + bit_r;
  assign k_small = k_r < CW'(2);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SD_IDLE: if (start) state_nxt = SD_SQ;
      SD_SQ:   state_nxt = k_small ? SD_DONE : SD_DIV;
      SD_DIV:  if (cnt_r == CNTW'(1)) state_nxt = SD_SUB;
      SD_SUB:  state_nxt = SD_ROOT;
      SD_ROOT: if (cnt_r == CNTW'(1)) state_nxt = SD_DONE;
      SD_DONE: state_nxt = start ? SD_SQ : SD_IDLE;
      default: state_nxt = SD_IDLE;
    endcase
  end

  always_comb begin
    done = 1'b0;
    unique case (state_r)
      SD_DONE: done = 1'b1;
      default: done = 1'b0;
    endcase
  end

  assign sd = root_r[SDW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && (state_r == SD_IDLE || state_r == SD_DONE)) begin
      k_r    <= k;
      a_r    <= s1_abs[AMAGW-1:0];
      s2_r   <= s2;
      root_r <= '0;
    end
    case (state_r)
      SD_SQ: begin
        sq_r  <= SQW'(a_r * a_r);
        quo_r <= '0;
        rem_r <= '0;
        cnt_r <= CNTW'(SQW);
      end
      SD_DIV: begin
        // long division of s1^2 by k, one quotient bit a cycle
        sq_r  <= {sq_r[SQW-2:0], 1'b0};
        quo_r <= {quo_r[SQW-2:0], rem_ge};
        rem_r <= rem_ge ? CW'(rem_sh - {1'b0, k_r}) : rem_sh[CW-1:0];
        cnt_r <= cnt_r - CNTW'(1);
      end
      SD_SUB: begin
        v_r    <= VW'({s_full[S2W-1:0], {FRAC_SHIFT{1'b0}}});
        root_r <= '0;
        bit_r  <= VW'(1) << (VW - 2);
        cnt_r  <= CNTW'(SDW);
      end
      SD_ROOT: begin
        if (v_r >= trial) begin
          v_r    <= v_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - CNTW'(1);
      end
      default: ;
    endcase
  end

endmodule

[design/lncc_qdiv.sv]
// ----------------------------------------------------------------------------
// lncc_qdiv
// Quotient unit: |C| * 2^30 / den, one bit a cycle, saturated to one in
// Q1.14.
// ----------------------------------------------------------------------------
module lncc_qdiv #(
  parameter int MAGW = 40,
  parameter int DENW = 56
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [MAGW-1:0]      mag,
  input  logic [DENW-1:0]      den,
  output lncc_pkg::qd_result_t res
);
  import lncc_pkg::*;

  localparam int CMPW  = ((MAGW + FRAC_SHIFT) > DENW) ? (MAGW + FRAC_SHIFT) : DENW;
  localparam int QCNTW = $clog2(QUOT_W + 1);

  qd_state_t        state_r, state_nxt;
  logic [DENW-1:0]  den_r;
  logic [DENW-1:0]  rem_r;
  logic [QUOT_W-1:0] q_r;
  logic [QCNTW-1:0] cnt_r;
  logic             sat_r;

  logic             sat_now;
  logic             take;
  logic [DENW:0]    rem_sh;
  logic             rem_ge;

  assign take    = start && (state_r == QD_IDLE || state_r == QD_DONE);
  assign sat_now = (CMPW'(mag) << FRAC_SHIFT) >= CMPW'(den);
  assign rem_sh  = {rem_r, 1'b0};
  assign rem_ge  = rem_sh >= {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      QD_IDLE, QD_DONE: begin
        if (start) begin
          state_nxt = sat_now ? QD_DONE : QD_RUN;
        end else begin
          state_nxt = QD_IDLE;
        end
      end
      QD_RUN:  if (cnt_r == QCNTW'(1)) state_nxt = QD_DONE;
      default: state_nxt = QD_IDLE;
    endcase
  end

  always_comb begin
    res.done = 1'b0;
    res.mag  = CORR_ONE;
    unique case (state_r)
      QD_DONE: begin
        res.done = 1'b1;
        if (!sat_r && q_r <= QUOT_W'(CORR_ONE)) begin
          res.mag = q_r[CORR_MAG_W-1:0];
        end
      end
      default: res.done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= QD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      den_r <= den;
      rem_r <= DENW'(mag);
      q_r   <= '0;
      sat_r <= sat_now;
      cnt_r <= QCNTW'(QUOT_W);
    end else if (state_r == QD_RUN) begin
      rem_r <= rem_ge ? DENW'(rem_sh - {1'b0, den_r}) : rem_sh[DENW-1:0];
      q_r   <= {q_r[QUOT_W-2:0], rem_ge};
      cnt_r <= cnt_r - QCNTW'(1);
    end
  end

endmodule

[design/lagged_normalized_cross_correlation.sv]
// ----------------------------------------------------------------------------
// lagged_normalized_cross_correlation
// Loads a window of (f, h) sample pairs, then gives the normalized
// correlation for every lag from -max_lag to +max_lag.
// ----------------------------------------------------------------------------
// Timing: while loading, one sample pair is taken every cycle. The transfer
// marked tlast drops in_tready until the last result has been taken. The
// block then makes a statistics pass over both sample memories, two
// standard-deviation runs and a denominator step, and for each of the
// 2*max_lag+1 lags a sweep through the memories (one read port per series),
// a divide and the output transfer. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module lagged_normalized_cross_correlation #(
  parameter int WINDOW_DEPTH  = lncc_pkg::WINDOW_DEPTH_DEF,
  parameter int MAX_LAG_LIMIT = lncc_pkg::MAX_LAG_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // tdata: sample_f [15:0], sample_h [31:16]
  input  logic [31:0]                   in_tdata,
  // tuser: f_missing [0], h_missing [1]
  input  logic [1:0]                    in_tuser,
  input  logic                          in_tlast,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // tdata: lag [5:0], corr_value [21:6], zero fill [23:22]
  output logic [lncc_pkg::OUT_DW-1:0]   out_tdata,
  // tuser: undefined [0], overflowed [1]
  output logic [1:0]                    out_tuser,
  output logic                          out_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lncc_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [lncc_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [lncc_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import lncc_pkg::*;

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int CW    = cnt_width(WINDOW_DEPTH);
  localparam int S1W   = s1_width(WINDOW_DEPTH);
  localparam int S2W   = s2_width(WINDOW_DEPTH);
  localparam int SDW   = sd_width(WINDOW_DEPTH);
  localparam int DENW  = 2 * SDW;
  localparam int PW    = 2 * SAMPLE_W;
  localparam int CACCW = PW + CW;
  localparam int MAGW  = CACCW - 1;
  localparam int JW    = ((CW > LAG_W) ? CW : LAG_W) + 2;

  ctl_state_t                 state_r, state_nxt;
  logic [MAX_LAG_W-1:0]       max_lag_r;
  logic [MAX_LAG_W-1:0]       ml_r;
  logic [CW-1:0]              fill_count_r;
  logic                       overflow_r;
  logic [CW-1:0]              i_r;
  logic                       s1_valid_r;
  logic                       s1_inr_r;
  logic                       s2_valid_r;
  logic                       s2_inr_r;
  logic                       s2_fok_r;
  logic                       s2_hok_r;
  logic signed [PW-1:0]       s2_pf_r;
  logic signed [PW-1:0]       s2_ph_r;
  logic signed [SAMPLE_W-1:0] s2_f_r;
  logic signed [SAMPLE_W-1:0] s2_h_r;
  logic [CW-1:0]              kf_r, kh_r;
  logic signed [S1W-1:0]      s1f_r, s1h_r;
  logic [S2W-1:0]             s2f_r, s2h_r;
  logic signed [CACCW-1:0]    c_r;
  logic [SDW-1:0]             sdf_r, sdh_r;
  logic [DENW-1:0]            den_r;
  logic                       undef_r;
  logic signed [LAG_W-1:0]    lag_r;
  logic signed [LAG_W-1:0]    out_lag_r;
  logic signed [CORR_W-1:0]   out_corr_r;
  logic                       out_undef_r;
  logic                       out_ovf_r;
  logic                       out_last_r;

  logic                       in_xfer;
  logic                       out_xfer;
  logic                       cfg_wr;
  logic                       store_room;
  logic                       sweep_active;
  logic                       issue;
  logic                       sweep_done;
  logic signed [LAG_W-1:0]    eff_lag;
  logic signed [JW-1:0]       j;
  logic                       j_inr;
  logic                       lag_is_last;
  logic [MAX_LAG_W-1:0]       ml_sat;
  entry_t                     wr_f, wr_h, rd_f, rd_h;
  logic signed [PW-1:0]       pf, ph;
  logic                       sd_start, sd_done, sd_sel_h;
  logic [SDW-1:0]             sd_val;
  logic                       qd_start;
  qd_result_t                 qd_res;
  logic signed [CACCW-1:0]    c_abs;
  logic signed [CORR_W-1:0]   corr_mag;

  assign in_xfer    = in_tvalid && in_tready;
  assign out_xfer   = out_tvalid && out_tready;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign store_room = fill_count_r != CW'(WINDOW_DEPTH);
  assign cfg_pready = 1'b1;

  assign ml_sat = (max_lag_r > MAX_LAG_W'(MAX_LAG_LIMIT)) ?
                  MAX_LAG_W'(MAX_LAG_LIMIT) : max_lag_r;
  assign lag_is_last = lag_r == $signed({1'b0, ml_r});

  // sweep address generation; the statistics pass runs at lag zero
  assign sweep_active = state_r == ST_STATS || state_r == ST_SWEEP;
  assign issue        = sweep_active && (i_r != fill_count_r);
  assign sweep_done   = sweep_active && !issue && !s1_valid_r && !s2_valid_r;
  assign eff_lag      = (state_r == ST_SWEEP) ? lag_r : '0;
  assign j            = $signed({{(JW-CW){1'b0}}, i_r}) + JW'(eff_lag);
  assign j_inr        = !j[JW-1] && (j < $signed({{(JW-CW){1'b0}}, fill_count_r}));

  assign wr_f.missing = in_tuser[0];
  assign wr_f.value   = in_tdata[SAMPLE_W-1:0];
  assign wr_h.missing = in_tuser[1];
  assign wr_h.value   = in_tdata[2*SAMPLE_W-1:SAMPLE_W];

  lncc_store #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (in_xfer && store_room),
    .wr_addr   (fill_count_r[AW-1:0]),
    .wr_f      (wr_f),
    .wr_h      (wr_h),
    .rd_en     (issue),
    .rd_addr_f (i_r[AW-1:0]),
    .rd_addr_h (j[AW-1:0]),
    .rd_f      (rd_f),
    .rd_h      (rd_h)
  );

  assign pf = rd_f.value * ((state_r == ST_STATS) ? rd_f.value : rd_h.value);
  assign ph = rd_h.value * rd_h.value;

  lncc_sd #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_sd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sd_start),
    .k     (sd_sel_h ? kh_r : kf_r),
    .s1    (sd_sel_h ? s1h_r : s1f_r),
    .s2    (sd_sel_h ? s2h_r : s2f_r),
    .done  (sd_done),
    .sd    (sd_val)
  );

  assign c_abs = c_r[CACCW-1] ? -c_r : c_r;

  lncc_qdiv #(
    .MAGW (MAGW),
    .DENW (DENW)
  ) u_qdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (qd_start),
    .mag   (c_abs[MAGW-1:0]),
    .den   (den_r),
    .res   (qd_res)
  );

  assign corr_mag = $signed({1'b0, qd_res.mag});

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:  if (in_xfer && in_tlast) state_nxt = ST_STATS;
      ST_STATS: if (sweep_done) state_nxt = ST_SD_F;
      ST_SD_F:  if (sd_done) state_nxt = ST_SD_H;
      ST_SD_H:  if (sd_done) state_nxt = ST_DEN;
      ST_DEN:   state_nxt = ST_SWEEP;
      ST_SWEEP: if (sweep_done) state_nxt = ST_DIV;
      ST_DIV:   if (qd_res.done) state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_tready) state_nxt = lag_is_last ? ST_LOAD : ST_SWEEP;
      end
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    sd_start   = 1'b0;
    sd_sel_h   = 1'b0;
    qd_start   = 1'b0;
    unique case (state_r)
      ST_LOAD:  in_tready = 1'b1;
      ST_STATS: sd_start = sweep_done;
      ST_SD_F: begin
        sd_start = sd_done;
        sd_sel_h = 1'b1;
      end
      ST_SWEEP: qd_start = sweep_done;
      ST_OUT:   out_tvalid = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      max_lag_r    <= MAX_LAG_RST;
      fill_count_r <= '0;
      overflow_r   <= 1'b0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      s1_valid_r <= issue;
      s2_valid_r <= s1_valid_r;
      if (cfg_wr) begin
        unique case (cfg_paddr[CFG_AW-1:2])
          REG_MAX_LAG: max_lag_r <= cfg_pwdata[MAX_LAG_W-1:0];
          default:     ;
        endcase
      end
      if (in_xfer) begin
        if (store_room) begin
          fill_count_r <= fill_count_r + CW'(1);
        end else begin
          overflow_r <= 1'b1;
        end
      end
      // window done: empty the store
      if (out_xfer && lag_is_last) begin
        fill_count_r <= '0;
        overflow_r   <= 1'b0;
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[CFG_AW-1:2])
      REG_MAX_LAG: cfg_prdata = CFG_DW'(max_lag_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // sweep pipeline: address, memory data, products, accumulate
  always_ff @(posedge clk) begin
    if (issue) begin
      i_r <= i_r + CW'(1);
    end
    s1_inr_r <= j_inr;
    s2_inr_r <= s1_inr_r;
    s2_fok_r <= !rd_f.missing;
    s2_hok_r <= !rd_h.missing;
    s2_pf_r  <= pf;
    s2_ph_r  <= ph;
    s2_f_r   <= rd_f.value;
    s2_h_r   <= rd_h.value;

    if (s2_valid_r && state_r == ST_STATS) begin
      if (s2_fok_r) begin
        kf_r  <= kf_r + CW'(1);
        s1f_r <= s1f_r + S1W'(s2_f_r);
        s2f_r <= s2f_r + S2W'($unsigned(s2_pf_r));
      end
      if (s2_hok_r) begin
        kh_r  <= kh_r + CW'(1);
        s1h_r <= s1h_r + S1W'(s2_h_r);
        s2h_r <= s2h_r + S2W'($unsigned(s2_ph_r));
      end
    end
    if (s2_valid_r && state_r == ST_SWEEP && s2_inr_r && s2_fok_r && s2_hok_r) begin
      c_r <= c_r + CACCW'(s2_pf_r);
    end

    if (in_xfer && in_tlast) begin
      i_r   <= '0;
      ml_r  <= ml_sat;
      kf_r  <= '0;
      kh_r  <= '0;
      s1f_r <= '0;
      s1h_r <= '0;
      s2f_r <= '0;
      s2h_r <= '0;
    end
    if (state_r == ST_SD_F && sd_done) sdf_r <= sd_val;
    if (state_r == ST_SD_H && sd_done) sdh_r <= sd_val;
    if (state_r == ST_DEN) begin
      den_r   <= DENW'(sdf_r * sdh_r);
      undef_r <= (kf_r < CW'(2)) || (kh_r < CW'(2)) || (sdf_r == '0) || (sdh_r == '0);
      lag_r   <= -$signed({1'b0, ml_r});
      i_r     <= '0;
      c_r     <= '0;
    end
    if (state_r == ST_DIV && qd_res.done) begin
      out_lag_r   <= lag_r;
      out_undef_r <= undef_r;
      out_ovf_r   <= overflow_r;
      out_last_r  <= lag_is_last;
      if (undef_r) begin
        out_corr_r <= '0;
      end else begin
        out_corr_r <= c_r[CACCW-1] ? -corr_mag : corr_mag;
      end
    end
    // advance to the next lag
    if (out_xfer && !lag_is_last) begin
      lag_r <= lag_r + LAG_W'(1);
      i_r   <= '0;
      c_r   <= '0;
    end
  end

  assign out_tdata = {{(OUT_DW-CORR_W-LAG_W){1'b0}}, out_corr_r, out_lag_r};
  assign out_tuser = {out_ovf_r, out_undef_r};
  assign out_tlast = out_last_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and result sides active together");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= CW'(WINDOW_DEPTH))
    else $error("fill count beyond store depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |-> fill_count_r == CW'(WINDOW_DEPTH))
    else $error("overflow flagged with room left in the store");

  a_window_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_tlast |=> in_tready && fill_count_r == '0 && !overflow_r)
    else $error("window not emptied after final lag");

  a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_corr_r <= $signed({1'b0, CORR_ONE})) &&
                   (out_corr_r >= -$signed({1'b0, CORR_ONE})))
    else $error("correlation outside plus or minus one");

endmodule
